@@ rtl/fts_pkg.sv @@
// Shared constants, codes and handshake structs for the frame time statistics block.
// No dependencies; every other file uses this package.
package fts_pkg;

    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int WINDOW_BITS_DEF   = 16;
    localparam int OUT_W             = 32;   // width of the reported statistics
    localparam int PCT_W             = 7;
    localparam int CNT_W             = 32;   // call counter, total count, divisor
    localparam int ACC_W             = 64;   // running sums, saturating
    localparam int CFG_IDX_W         = 2;
    localparam int QUEUE_DEPTH       = 2;
    localparam int WINDOW_LENGTH_RST = 100;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_LOWER_LIMIT   = 2'd1,
        CFG_UPPER_LIMIT   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_COUNT,
        OP_SAMPLE
    } op_t;

    typedef enum logic [1:0] {
        BAND_IN,
        BAND_LOW,
        BAND_HIGH
    } band_t;

    typedef struct packed {
        op_t   op;
        band_t band;
    } item_ctl_t;

    typedef struct packed {
        logic start;
        logic pct;     // short division: 7 quotient bits
    } div_req_t;

    typedef struct packed {
        logic done;
        logic sat;     // quotient does not fit
    } div_rsp_t;

endpackage

@@ rtl/fts_front.sv @@
// Front end: takes input transfers, counts calls and classifies each item.
// Depends on fts_pkg; feeds fts_queue.
module fts_front #(
    parameter int SAMPLE_BITS = fts_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = fts_pkg::WINDOW_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [SAMPLE_BITS-1:0]   sample,
    input  logic [WINDOW_BITS-1:0]   window_length,
    input  logic [SAMPLE_BITS-1:0]   lower_limit,
    input  logic [SAMPLE_BITS-1:0]   upper_limit,
    input  logic                     q_full,
    output logic                     q_push,
    output fts_pkg::item_ctl_t       q_ctl,
    output logic [fts_pkg::CNT_W-1:0] q_calls,
    output logic [SAMPLE_BITS-1:0]   q_sample
);
    import fts_pkg::*;

    logic [CNT_W-1:0] calls_reg;
    logic [CNT_W-1:0] calls_next;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_sample = sample;
    assign q_calls  = calls_next;

    // call counter wraps, a clear does not count
    assign calls_next = command ? calls_reg : calls_reg + CNT_W'(1);

    always_comb
    begin
        priority if (command)
            q_ctl.op = OP_CLEAR;
        else if (window_length > WINDOW_BITS'(1))
            q_ctl.op = OP_SAMPLE;
        else
            q_ctl.op = OP_COUNT;

        // lower limit is tested first
        priority if (sample < lower_limit)
            q_ctl.band = BAND_LOW;
        else if (sample > upper_limit)
            q_ctl.band = BAND_HIGH;
        else
            q_ctl.band = BAND_IN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calls_reg <= '0;
        end
        else if (q_push)
        begin
            calls_reg <= calls_next;
        end
    end

endmodule

@@ rtl/fts_queue.sv @@
// Short register queue between the front end and the back end.
// Generic width; depth default from fts_pkg.
module fts_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = fts_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push_ok;
    logic              pop_ok;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            unique case ({push_ok, pop_ok})
                2'b10:   fill_reg <= fill_reg + FILL_W'(1);
                2'b01:   fill_reg <= fill_reg - FILL_W'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

@@ rtl/fts_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Full mode gives QW quotient bits, short mode 7; overflow is flagged up front.
module fts_divider #(
    parameter int QW = fts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fts_pkg::div_req_t         req,
    input  logic [fts_pkg::ACC_W-1:0] dividend,
    input  logic [fts_pkg::CNT_W-1:0] divisor,
    output fts_pkg::div_rsp_t         rsp,
    output logic [QW-1:0]             quotient
);
    import fts_pkg::*;

    localparam int STEP_W = $clog2(QW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [QW-1:0]     shf_reg;
    logic [QW-1:0]     quo_reg;

    logic [ACC_W-1:0]  head;
    logic              head_ovf;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_diff;
    logic              trial_ge;

    // bits above the quotient field form the first remainder
    assign head     = req.pct ? (dividend >> PCT_W) : (dividend >> QW);
    assign head_ovf = (head >= ACC_W'(divisor));

    assign trial      = {rem_reg, shf_reg[QW-1]};
    assign trial_ge   = (trial >= {1'b0, dvs_reg});
    assign trial_diff = trial - {1'b0, dvs_reg};

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            shf_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            priority if (req.start)
            begin
                dvs_reg <= divisor;
                quo_reg <= '0;
                if (head_ovf)
                begin
                    sat_reg  <= 1'b1;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    sat_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                    rem_reg  <= head[CNT_W-1:0];
                    shf_reg  <= req.pct ? {dividend[PCT_W-1:0], {(QW - PCT_W){1'b0}}}
                                        : dividend[QW-1:0];
                    step_reg <= req.pct ? STEP_W'(PCT_W) : STEP_W'(QW);
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_reg  <= {quo_reg[QW-2:0], trial_ge};
                shf_reg  <= shf_reg << 1;
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/fts_back.sv @@
// Back end: statistics registers, division sequencing and the output register.
// Depends on fts_pkg; pops fts_queue and drives fts_divider.
module fts_back #(
    parameter int SAMPLE_BITS = fts_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = fts_pkg::WINDOW_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    output logic                      q_pop,
    input  fts_pkg::item_ctl_t        q_ctl,
    input  logic [fts_pkg::CNT_W-1:0] q_calls,
    input  logic [SAMPLE_BITS-1:0]    q_sample,
    input  logic [WINDOW_BITS-1:0]    window_length,
    output fts_pkg::div_req_t         div_req,
    output logic [fts_pkg::ACC_W-1:0] div_dividend,
    output logic [fts_pkg::CNT_W-1:0] div_divisor,
    input  fts_pkg::div_rsp_t         div_rsp,
    input  logic [SAMPLE_BITS-1:0]    div_quotient,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [fts_pkg::OUT_W-1:0] calls_seen,
    output logic [fts_pkg::OUT_W-1:0] all_min,
    output logic [fts_pkg::OUT_W-1:0] all_max,
    output logic [fts_pkg::OUT_W-1:0] all_mean,
    output logic [fts_pkg::OUT_W-1:0] win_min,
    output logic [fts_pkg::OUT_W-1:0] win_max,
    output logic [fts_pkg::OUT_W-1:0] win_mean,
    output logic [fts_pkg::PCT_W-1:0] out_percent,
    output logic                      window_closed
);
    import fts_pkg::*;

    localparam int NUM_W = WINDOW_BITS + 8;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALL_GO,
        ST_ALL_WAIT,
        ST_WIN_GO,
        ST_WIN_WAIT,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_EMIT
    } state_t;

    state_t                 state_reg;

    logic [CNT_W-1:0]       item_calls_reg;
    logic                   closed_reg;
    logic [CNT_W-1:0]       total_count_reg;
    logic [ACC_W-1:0]       total_sum_reg;
    logic [SAMPLE_BITS-1:0] omin_reg;
    logic [SAMPLE_BITS-1:0] omax_reg;
    logic [SAMPLE_BITS-1:0] omean_reg;
    logic [WINDOW_BITS-1:0] wpos_reg;
    logic [ACC_W-1:0]       wsum_reg;
    logic [SAMPLE_BITS-1:0] wmin_reg;
    logic [SAMPLE_BITS-1:0] wmax_reg;
    logic [WINDOW_BITS-1:0] below_reg;
    logic [WINDOW_BITS-1:0] above_reg;
    logic [SAMPLE_BITS-1:0] wmean_reg;
    logic [PCT_W-1:0]       pct_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       calls_out_reg;
    logic [OUT_W-1:0]       all_min_reg;
    logic [OUT_W-1:0]       all_max_reg;
    logic [OUT_W-1:0]       all_mean_reg;
    logic [OUT_W-1:0]       win_min_reg;
    logic [OUT_W-1:0]       win_max_reg;
    logic [OUT_W-1:0]       win_mean_reg;
    logic [PCT_W-1:0]       pct_out_reg;
    logic                   closed_out_reg;

    logic [CNT_W-1:0]       count_next;
    logic [ACC_W-1:0]       tsum_next;
    logic [SAMPLE_BITS-1:0] omin_next;
    logic [SAMPLE_BITS-1:0] omax_next;
    logic [WINDOW_BITS-1:0] wpos_next;
    logic [ACC_W-1:0]       wsum_next;
    logic [SAMPLE_BITS-1:0] wmin_next;
    logic [SAMPLE_BITS-1:0] wmax_next;
    logic [WINDOW_BITS-1:0] below_next;
    logic [WINDOW_BITS-1:0] above_next;
    logic                   first_sample;
    logic                   window_open;
    logic                   count_room;
    logic [NUM_W-1:0]       out_sum;
    logic [NUM_W-1:0]       pct_num;
    logic                   out_free;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    assign window_open = (wpos_reg < window_length);
    assign count_room  = (total_count_reg != CNT_MAX);
    assign out_sum     = NUM_W'(below_reg) + NUM_W'(above_reg);
    assign pct_num     = out_sum * NUM_W'(PCT_MAX);
    assign out_free    = !out_valid_reg || !out_stall;
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;

    // statistics after one sample, in the order the updates depend on each other
    always_comb
    begin
        count_next = total_count_reg;
        tsum_next  = total_sum_reg;
        omin_next  = omin_reg;
        omax_next  = omax_reg;
        wpos_next  = wpos_reg;
        wsum_next  = wsum_reg;
        wmin_next  = wmin_reg;
        wmax_next  = wmax_reg;
        below_next = below_reg;
        above_next = above_reg;

        if (count_room)
        begin
            count_next = total_count_reg + CNT_W'(1);
            tsum_next  = sat_add(total_sum_reg, ACC_W'(q_sample));
        end

        first_sample = (count_next == CNT_W'(1));
        priority if (first_sample)
        begin
            omin_next = q_sample;
            omax_next = q_sample;
            wmin_next = q_sample;
            wmax_next = q_sample;
        end
        else if (q_sample < omin_reg)
            omin_next = q_sample;
        else if (q_sample > omax_reg)
            omax_next = q_sample;

        if (window_open)
        begin
            if (wpos_reg == '0)
            begin
                wmin_next = q_sample;
                wmax_next = q_sample;
            end
            wsum_next = sat_add(wsum_reg, ACC_W'(q_sample));
            priority if (q_sample < wmin_next)
                wmin_next = q_sample;
            else if (q_sample > wmax_next)
                wmax_next = q_sample;
            unique case (q_ctl.band)
                BAND_LOW:  below_next = below_reg + WINDOW_BITS'(1);
                BAND_HIGH: above_next = above_reg + WINDOW_BITS'(1);
                default:   ;
            endcase
            wpos_next = wpos_reg + WINDOW_BITS'(1);
        end
    end

    always_comb
    begin
        div_req      = '0;
        div_dividend = total_sum_reg;
        div_divisor  = total_count_reg;
        unique case (state_reg)
            ST_ALL_GO:
            begin
                div_req.start = 1'b1;
            end
            ST_WIN_GO:
            begin
                div_req.start = 1'b1;
                div_dividend  = wsum_reg;
                div_divisor   = CNT_W'(window_length);
            end
            ST_PCT_GO:
            begin
                div_req.start = 1'b1;
                div_req.pct   = 1'b1;
                div_dividend  = ACC_W'(pct_num);
                div_divisor   = CNT_W'(window_length);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_calls_reg  <= '0;
            closed_reg      <= 1'b0;
            total_count_reg <= '0;
            total_sum_reg   <= '0;
            omin_reg        <= '0;
            omax_reg        <= '0;
            omean_reg       <= '0;
            wpos_reg        <= '0;
            wsum_reg        <= '0;
            wmin_reg        <= '0;
            wmax_reg        <= '0;
            below_reg       <= '0;
            above_reg       <= '0;
            wmean_reg       <= '0;
            pct_reg         <= '0;
            out_valid_reg   <= 1'b0;
            calls_out_reg   <= '0;
            all_min_reg     <= '0;
            all_max_reg     <= '0;
            all_mean_reg    <= '0;
            win_min_reg     <= '0;
            win_max_reg     <= '0;
            win_mean_reg    <= '0;
            pct_out_reg     <= '0;
            closed_out_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        item_calls_reg <= q_calls;
                        closed_reg     <= 1'b0;
                        unique case (q_ctl.op)
                            OP_CLEAR:
                            begin
                                total_count_reg <= '0;
                                total_sum_reg   <= '0;
                                omin_reg        <= '0;
                                omax_reg        <= '0;
                                omean_reg       <= '0;
                                wpos_reg        <= '0;
                                wsum_reg        <= '0;
                                wmin_reg        <= '0;
                                wmax_reg        <= '0;
                                below_reg       <= '0;
                                above_reg       <= '0;
                                wmean_reg       <= '0;
                                pct_reg         <= '0;
                                state_reg       <= ST_EMIT;
                            end
                            OP_SAMPLE:
                            begin
                                total_count_reg <= count_next;
                                total_sum_reg   <= tsum_next;
                                omin_reg        <= omin_next;
                                omax_reg        <= omax_next;
                                wpos_reg        <= wpos_next;
                                wsum_reg        <= wsum_next;
                                wmin_reg        <= wmin_next;
                                wmax_reg        <= wmax_next;
                                below_reg       <= below_next;
                                above_reg       <= above_next;
                                if (first_sample)
                                begin
                                    pct_reg <= '0;
                                end
                                // a full window is closed by this sample
                                closed_reg <= !window_open;
                                priority if (count_room)
                                    state_reg <= ST_ALL_GO;
                                else if (!window_open)
                                    state_reg <= ST_WIN_GO;
                                else
                                    state_reg <= ST_EMIT;
                            end
                            OP_COUNT:
                            begin
                                state_reg <= ST_EMIT;
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_ALL_GO:
                begin
                    state_reg <= ST_ALL_WAIT;
                end
                ST_ALL_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        omean_reg <= div_rsp.sat ? SAMPLE_MAX : div_quotient;
                        state_reg <= closed_reg ? ST_WIN_GO : ST_EMIT;
                    end
                end
                ST_WIN_GO:
                begin
                    state_reg <= ST_WIN_WAIT;
                end
                ST_WIN_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        wmean_reg <= div_rsp.sat ? SAMPLE_MAX : div_quotient;
                        state_reg <= ST_PCT_GO;
                    end
                end
                ST_PCT_GO:
                begin
                    state_reg <= ST_PCT_WAIT;
                end
                ST_PCT_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        pct_reg   <= (div_rsp.sat || div_quotient[PCT_W-1:0] > PCT_MAX)
                                     ? PCT_MAX : div_quotient[PCT_W-1:0];
                        wsum_reg  <= '0;
                        wpos_reg  <= '0;
                        below_reg <= '0;
                        above_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        calls_out_reg  <= OUT_W'(item_calls_reg);
                        all_min_reg    <= OUT_W'(omin_reg);
                        all_max_reg    <= OUT_W'(omax_reg);
                        all_mean_reg   <= OUT_W'(omean_reg);
                        win_min_reg    <= OUT_W'(wmin_reg);
                        win_max_reg    <= OUT_W'(wmax_reg);
                        win_mean_reg   <= OUT_W'(wmean_reg);
                        pct_out_reg    <= pct_reg;
                        closed_out_reg <= closed_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign calls_seen    = calls_out_reg;
    assign all_min       = all_min_reg;
    assign all_max       = all_max_reg;
    assign all_mean      = all_mean_reg;
    assign win_min       = win_min_reg;
    assign win_max       = win_max_reg;
    assign win_mean      = win_mean_reg;
    assign out_percent   = pct_out_reg;
    assign window_closed = closed_out_reg;

endmodule

@@ rtl/frame_time_statistics.sv @@
// Frame time statistics, top level: configuration registers and the front/queue/back split.
// Depends on fts_pkg, fts_front, fts_queue, fts_divider and fts_back.
//
// Usage:
//   Input channel in_valid/in_stall carries command and sample; command 0 is a
//   duration sample, command 1 clears every statistic but the call count.
//   Output channel out_valid/out_stall returns one result per input transfer,
//   in order, showing the state after that item.
//   The user must write configuration (window_length, lower_limit, upper_limit) through
//   cfg_we/cfg_index/cfg_data only while no item is in flight, not enforced by the block.
// Timing:
//   The back end runs one item at a time; its shared one-bit-per-cycle divider
//   sets the cost. A sample divides once for the overall mean; a window-closing
//   sample adds the window mean and percentage, one division each. Clears and
//   samples with a window length of one or less skip the divider. The front end
//   keeps taking items into a two-entry queue while the back end works.
// Reset and stall:
//   Reset clears every statistic and the call count and loads the register
//   defaults. A stalled result holds in the output register; the back end then
//   waits, the queue fills and in_stall rises.
module frame_time_statistics #(
    parameter int SAMPLE_BITS = fts_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = fts_pkg::WINDOW_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [fts_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((SAMPLE_BITS > WINDOW_BITS) ? SAMPLE_BITS : WINDOW_BITS)-1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [SAMPLE_BITS-1:0]                sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [fts_pkg::OUT_W-1:0]             calls_seen,
    output logic [fts_pkg::OUT_W-1:0]             all_min,
    output logic [fts_pkg::OUT_W-1:0]             all_max,
    output logic [fts_pkg::OUT_W-1:0]             all_mean,
    output logic [fts_pkg::OUT_W-1:0]             win_min,
    output logic [fts_pkg::OUT_W-1:0]             win_max,
    output logic [fts_pkg::OUT_W-1:0]             win_mean,
    output logic [fts_pkg::PCT_W-1:0]             out_percent,
    output logic                                  window_closed
);
    import fts_pkg::*;

    localparam int ITEM_W = $bits(item_ctl_t) + CNT_W + SAMPLE_BITS;

    logic [WINDOW_BITS-1:0] window_length_reg;
    logic [SAMPLE_BITS-1:0] lower_limit_reg;
    logic [SAMPLE_BITS-1:0] upper_limit_reg;

    logic                   f_push;
    item_ctl_t              f_ctl;
    logic [CNT_W-1:0]       f_calls;
    logic [SAMPLE_BITS-1:0] f_sample;

    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [ITEM_W-1:0]      q_rd_data;
    item_ctl_t              b_ctl;
    logic [CNT_W-1:0]       b_calls;
    logic [SAMPLE_BITS-1:0] b_sample;

    div_req_t               div_req;
    div_rsp_t               div_rsp;
    logic [ACC_W-1:0]       div_dividend;
    logic [CNT_W-1:0]       div_divisor;
    logic [SAMPLE_BITS-1:0] div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_BITS'(WINDOW_LENGTH_RST);
            lower_limit_reg   <= '0;
            upper_limit_reg   <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[WINDOW_BITS-1:0];
                CFG_LOWER_LIMIT:   lower_limit_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_UPPER_LIMIT:   upper_limit_reg   <= cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    fts_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .sample        (sample),
        .window_length (window_length_reg),
        .lower_limit   (lower_limit_reg),
        .upper_limit   (upper_limit_reg),
        .q_full        (q_full),
        .q_push        (f_push),
        .q_ctl         (f_ctl),
        .q_calls       (f_calls),
        .q_sample      (f_sample)
    );

    fts_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_push),
        .wr_data ({f_ctl, f_calls, f_sample}),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {b_ctl, b_calls, b_sample} = q_rd_data;

    fts_divider #(
        .QW (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    fts_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_ctl         (b_ctl),
        .q_calls       (b_calls),
        .q_sample      (b_sample),
        .window_length (window_length_reg),
        .div_req       (div_req),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_rsp       (div_rsp),
        .div_quotient  (div_quotient),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .calls_seen    (calls_seen),
        .all_min       (all_min),
        .all_max       (all_max),
        .all_mean      (all_mean),
        .win_min       (win_min),
        .win_max       (win_max),
        .win_mean      (win_mean),
        .out_percent   (out_percent),
        .window_closed (window_closed)
    );

endmodule
